// ===== hdl/rti_pkg.sv =====
package rti_pkg;

    // Input commands.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TEST = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_CULL = 1'b0;
    localparam logic CFG_EPS  = 1'b1;

    // Float constants and reset values.
    localparam logic [31:0] FP_ZERO     = 32'h0000_0000;
    localparam logic [31:0] FP_ONE      = 32'h3F80_0000;
    localparam logic [31:0] FP_QNAN     = 32'h7FC0_0000;
    localparam logic [31:0] FP_SIGN     = 32'h8000_0000;
    localparam logic [31:0] EPS_DEFAULT = 32'h3727_C5AC;

    // Reciprocal unit geometry: number of iteration stages and quotient bits retired per stage.
    localparam int RcpStages    = 7;
    localparam int RcpBitsStage = 4;

    typedef logic [2:0][31:0] t_vec3;

    // Everything a test beat carries into the pipeline.
    typedef struct packed {
        t_vec3       org;
        t_vec3       dir;
        t_vec3       v0;
        t_vec3       v1;
        t_vec3       v2;
        logic [31:0] best;
        logic [30:0] tri_id;
    } t_ray;

    // Values that ride alongside the reciprocal unit.
    typedef struct packed {
        logic [31:0] u;
        logic [31:0] v;
        logic [31:0] t;
        logic [31:0] best;
        logic [30:0] tri_id;
        logic        ok_pre;
    } t_side;

    // Class of the reciprocal result.
    typedef enum logic [1:0] {
        RCP_FIN,
        RCP_NAN,
        RCP_INF,
        RCP_ZERO
    } t_rcp_cls;

    // One stage of the reciprocal pipeline.
    typedef struct packed {
        t_rcp_cls           cls;
        logic               sgn;
        logic signed [11:0] ed;
        logic [23:0]        md;
        logic [24:0]        rem;
        logic [27:0]        q;
        t_side              side;
    } t_rcp;

    // Leading zero count of a 48-bit word.
    function automatic logic [5:0] fp_lzc48(input logic [47:0] x);
        logic [5:0] n;
        logic       found;
        n = 6'd0;
        found = 1'b0;
        for (int i = 47; i >= 0; i--) begin
            if (!found) begin
                if (x[i]) begin
                    found = 1'b1;
                end else begin
                    n = n + 6'd1;
                end
            end
        end
        return n;
    endfunction

    function automatic logic fp_nan(input logic [31:0] a);
        return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    endfunction

    // Round to nearest even and pack. The significand has its leading one at
    // bit 26, then 23 fraction bits, a guard bit and two sticky bits; e is
    // the biased exponent of the leading one.
    function automatic logic [31:0] fp_round(input logic s, input logic signed [11:0] e,
                                             input logic [26:0] m);
        logic [26:0] mm;
        logic [11:0] sh;
        logic [26:0] lost;
        logic [7:0]  ef;
        logic        up;
        logic [30:0] r;
        if (e >= 12'sd255) begin
            return {s, 8'hFF, 23'd0};
        end
        if (e <= 12'sd0) begin
            sh = 12'(12'sd1 - e);
            if (sh >= 12'd27) begin
                mm = {26'd0, |m};
            end else begin
                lost = m & ~({27{1'b1}} << sh[4:0]);
                mm = (m >> sh[4:0]) | {26'd0, |lost};
            end
            ef = 8'd0;
        end else begin
            mm = m;
            ef = e[7:0];
        end
        up = mm[2] & ((|mm[1:0]) | mm[3]);
        r = {ef, mm[25:3]} + {30'd0, up};
        return {s, r};
    endfunction

    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic               s;
        logic               a_inf, b_inf, a_zero, b_zero;
        logic [7:0]         ea, eb;
        logic [23:0]        ma, mb;
        logic [47:0]        p, pn;
        logic [5:0]         lz;
        logic signed [11:0] e;
        s = a[31] ^ b[31];
        a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
        b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
        a_zero = (a[30:0] == 31'd0);
        b_zero = (b[30:0] == 31'd0);
        if (fp_nan(a) || fp_nan(b) || (a_inf && b_zero) || (b_inf && a_zero)) begin
            return FP_QNAN;
        end
        if (a_inf || b_inf) begin
            return {s, 8'hFF, 23'd0};
        end
        if (a_zero || b_zero) begin
            return {s, 31'd0};
        end
        ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        ma = {a[30:23] != 8'd0, a[22:0]};
        mb = {b[30:23] != 8'd0, b[22:0]};
        p = ma * mb;
        lz = fp_lzc48(p);
        pn = p << lz;
        e = $signed({4'd0, ea}) + $signed({4'd0, eb}) - 12'sd126 - $signed({6'd0, lz});
        return fp_round(s, e, {pn[47:22], |pn[21:0]});
    endfunction

    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        logic [31:0]        x, y;
        logic               x_inf, y_inf;
        logic [7:0]         ex, ey, d;
        logic [26:0]        mx, my, mys, lost;
        logic [27:0]        sum, sn;
        logic [5:0]         lz;
        logic signed [11:0] e;
        if (fp_nan(a) || fp_nan(b)) begin
            return FP_QNAN;
        end
        // Larger magnitude first.
        if (a[30:0] < b[30:0]) begin
            x = b;
            y = a;
        end else begin
            x = a;
            y = b;
        end
        x_inf = (x[30:23] == 8'hFF);
        y_inf = (y[30:23] == 8'hFF);
        if (x_inf && y_inf && (x[31] != y[31])) begin
            return FP_QNAN;
        end
        if (x_inf) begin
            return x;
        end
        ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
        ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
        mx = {x[30:23] != 8'd0, x[22:0], 3'd0};
        my = {y[30:23] != 8'd0, y[22:0], 3'd0};
        d = ex - ey;
        if (d >= 8'd27) begin
            mys = {26'd0, |my};
        end else begin
            lost = my & ~({27{1'b1}} << d[4:0]);
            mys = (my >> d[4:0]) | {26'd0, |lost};
        end
        if (x[31] == y[31]) begin
            sum = {1'b0, mx} + {1'b0, mys};
        end else begin
            sum = {1'b0, mx} - {1'b0, mys};
        end
        if (sum == 28'd0) begin
            return {x[31] & y[31], 31'd0};
        end
        lz = fp_lzc48({sum, 20'd0});
        sn = sum << lz;
        e = $signed({4'd0, ex}) + 12'sd1 - $signed({6'd0, lz});
        return fp_round(x[31], e, {sn[27:2], |sn[1:0]});
    endfunction

    function automatic logic [31:0] fp_sub(input logic [31:0] a, input logic [31:0] b);
        return fp_add(a, b ^ FP_SIGN);
    endfunction

    // Order key: unsigned compare of keys matches float order, zeros merged.
    function automatic logic [31:0] fp_key(input logic [31:0] a);
        logic [31:0] c;
        c = (a[30:0] == 31'd0) ? FP_ZERO : a;
        return c[31] ? ~c : (c | FP_SIGN);
    endfunction

    function automatic logic fp_le(input logic [31:0] a, input logic [31:0] b);
        return !fp_nan(a) && !fp_nan(b) && (fp_key(a) <= fp_key(b));
    endfunction

    function automatic logic fp_lt(input logic [31:0] a, input logic [31:0] b);
        return !fp_nan(a) && !fp_nan(b) && (fp_key(a) < fp_key(b));
    endfunction

endpackage

// ===== hdl/rti_recip.sv =====
module rti_recip (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [31:0]   i_det,
    input  rti_pkg::t_side i_side,
    output logic          o_valid,
    output logic [31:0]   o_inv,
    output rti_pkg::t_side o_side
);

    rti_pkg::t_rcp r_st  [0:rti_pkg::RcpStages];
    logic          r_vld [0:rti_pkg::RcpStages];
    rti_pkg::t_rcp n_first;
    logic [31:0]   n_inv;
    logic [31:0]   r_inv;
    rti_pkg::t_side r_side;
    logic          r_ovld;

    // Unpack the determinant, classify it and normalize its significand.
    always_comb begin
        logic [7:0]  e_eff;
        logic [23:0] ma;
        logic [5:0]  lz;
        e_eff = (i_det[30:23] == 8'd0) ? 8'd1 : i_det[30:23];
        ma = {i_det[30:23] != 8'd0, i_det[22:0]};
        lz = rti_pkg::fp_lzc48({ma, 24'd0});
        n_first.sgn = i_det[31];
        n_first.md = ma << lz[4:0];
        n_first.ed = $signed({4'd0, e_eff}) - $signed({6'd0, lz});
        n_first.rem = 25'h080_0000;
        n_first.q = 28'd0;
        n_first.side = i_side;
        if (rti_pkg::fp_nan(i_det)) begin
            n_first.cls = rti_pkg::RCP_NAN;
        end else if (i_det[30:23] == 8'hFF) begin
            n_first.cls = rti_pkg::RCP_ZERO;
        end else if (i_det[30:0] == 31'd0) begin
            n_first.cls = rti_pkg::RCP_INF;
        end else begin
            n_first.cls = rti_pkg::RCP_FIN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0] <= n_first;
        end
    end

    // Restoring division of one by the significand, a few bits per stage.
    for (genvar k = 1; k <= rti_pkg::RcpStages; k++) begin : g_iter
        rti_pkg::t_rcp n_st;

        always_comb begin
            n_st = r_st[k-1];
            for (int i = 0; i < rti_pkg::RcpBitsStage; i++) begin
                if (n_st.rem >= {1'b0, n_st.md}) begin
                    n_st.rem = n_st.rem - {1'b0, n_st.md};
                    n_st.q = {n_st.q[26:0], 1'b1};
                end else begin
                    n_st.q = {n_st.q[26:0], 1'b0};
                end
                n_st.rem = n_st.rem << 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= r_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[k] <= n_st;
            end
        end
    end

    // Round the quotient and apply the special cases.
    always_comb begin
        rti_pkg::t_rcp      f;
        logic               st;
        logic [26:0]        m;
        logic signed [11:0] e;
        f = r_st[rti_pkg::RcpStages];
        st = (f.rem != 25'd0);
        if (f.q[27]) begin
            m = {f.q[27:2], f.q[1] | f.q[0] | st};
            e = 12'sd254 - f.ed;
        end else begin
            m = {f.q[26:1], f.q[0] | st};
            e = 12'sd253 - f.ed;
        end
        unique case (f.cls)
            rti_pkg::RCP_NAN:  n_inv = rti_pkg::FP_QNAN;
            rti_pkg::RCP_INF:  n_inv = {f.sgn, 8'hFF, 23'd0};
            rti_pkg::RCP_ZERO: n_inv = {f.sgn, 31'd0};
            default:           n_inv = rti_pkg::fp_round(f.sgn, e, m);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (i_en) begin
            r_ovld <= r_vld[rti_pkg::RcpStages];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_inv <= n_inv;
            r_side <= r_st[rti_pkg::RcpStages].side;
        end
    end

    assign o_valid = r_ovld;
    assign o_inv = r_inv;
    assign o_side = r_side;

endmodule

// ===== hdl/rti_core.sv =====
module rti_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_test,
    input  rti_pkg::t_ray i_ray,
    input  logic          i_cull,
    input  logic [31:0]   i_eps,
    output logic          o_en,
    output logic          o_valid,
    input  logic          i_ready,
    output logic          o_hit,
    output logic [31:0]   o_hit_t,
    output logic [31:0]   o_hit_u,
    output logic [31:0]   o_hit_v,
    output logic [30:0]   o_hit_tri_id
);

    logic en;

    // Stage 1: captured ray and triangle.
    rti_pkg::t_ray r1;
    logic          r1_vld;
    // Stage 2: edges and origin offset.
    rti_pkg::t_vec3 r2_e0, r2_e1, r2_tv, r2_dir;
    logic [31:0]    r2_best;
    logic [30:0]    r2_tri;
    logic           r2_vld;
    // Stage 3: cross product terms.
    logic [5:0][31:0] r3_pm, r3_qm;
    rti_pkg::t_vec3   r3_e0, r3_e1, r3_tv, r3_dir;
    logic [31:0]      r3_best;
    logic [30:0]      r3_tri;
    logic             r3_vld;
    // Stage 4: cross products.
    rti_pkg::t_vec3 r4_p, r4_q, r4_e0, r4_e1, r4_tv, r4_dir;
    logic [31:0]    r4_best;
    logic [30:0]    r4_tri;
    logic           r4_vld;
    // Stage 5: dot product terms.
    rti_pkg::t_vec3 r5_dm, r5_um, r5_vm, r5_tm;
    logic [31:0]    r5_best;
    logic [30:0]    r5_tri;
    logic           r5_vld;
    // Stage 6: partial sums.
    logic [31:0] r6_d01, r6_u01, r6_v01, r6_t01, r6_d2, r6_u2, r6_v2, r6_t2;
    logic [31:0] r6_best;
    logic [30:0] r6_tri;
    logic        r6_vld;
    // Stage 7: det, u, v, t.
    logic [31:0] r7_det, r7_u, r7_v, r7_t, r7_best;
    logic [30:0] r7_tri;
    logic        r7_vld;
    // Reciprocal path.
    rti_pkg::t_side n_side, rcp_side;
    logic           rcp_vld;
    logic [31:0]    rcp_inv;
    // Stage 8: scaled values.
    logic [31:0] r8_u, r8_v, r8_t, r8_best;
    logic [30:0] r8_tri;
    logic        r8_ok, r8_vld;
    // Output register.
    logic        r9_vld, r9_hit;
    logic [31:0] r9_t, r9_u, r9_v;
    logic [30:0] r9_tri;
    logic        n_ok;

    // The whole pipe moves when the output register is free or being taken.
    assign en = !r9_vld || i_ready;
    assign o_en = en;

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
            r7_vld <= 1'b0;
            r8_vld <= 1'b0;
            r9_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_test;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
            r6_vld <= r5_vld;
            r7_vld <= r6_vld;
            r8_vld <= rcp_vld;
            r9_vld <= r8_vld;
        end
    end

    // Stages 1 through 4: edges, cross terms and cross products.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1 <= i_ray;

            for (int i = 0; i < 3; i++) begin
                r2_e0[i] <= rti_pkg::fp_sub(r1.v1[i], r1.v0[i]);
                r2_e1[i] <= rti_pkg::fp_sub(r1.v2[i], r1.v0[i]);
                r2_tv[i] <= rti_pkg::fp_sub(r1.org[i], r1.v0[i]);
            end
            r2_dir <= r1.dir;
            r2_best <= r1.best;
            r2_tri <= r1.tri_id;

            r3_pm[0] <= rti_pkg::fp_mul(r2_dir[1], r2_e1[2]);
            r3_pm[1] <= rti_pkg::fp_mul(r2_dir[2], r2_e1[1]);
            r3_pm[2] <= rti_pkg::fp_mul(r2_dir[2], r2_e1[0]);
            r3_pm[3] <= rti_pkg::fp_mul(r2_dir[0], r2_e1[2]);
            r3_pm[4] <= rti_pkg::fp_mul(r2_dir[0], r2_e1[1]);
            r3_pm[5] <= rti_pkg::fp_mul(r2_dir[1], r2_e1[0]);
            r3_qm[0] <= rti_pkg::fp_mul(r2_tv[1], r2_e0[2]);
            r3_qm[1] <= rti_pkg::fp_mul(r2_tv[2], r2_e0[1]);
            r3_qm[2] <= rti_pkg::fp_mul(r2_tv[2], r2_e0[0]);
            r3_qm[3] <= rti_pkg::fp_mul(r2_tv[0], r2_e0[2]);
            r3_qm[4] <= rti_pkg::fp_mul(r2_tv[0], r2_e0[1]);
            r3_qm[5] <= rti_pkg::fp_mul(r2_tv[1], r2_e0[0]);
            r3_e0 <= r2_e0;
            r3_e1 <= r2_e1;
            r3_tv <= r2_tv;
            r3_dir <= r2_dir;
            r3_best <= r2_best;
            r3_tri <= r2_tri;

            for (int i = 0; i < 3; i++) begin
                r4_p[i] <= rti_pkg::fp_sub(r3_pm[2*i], r3_pm[2*i+1]);
                r4_q[i] <= rti_pkg::fp_sub(r3_qm[2*i], r3_qm[2*i+1]);
            end
            r4_e0 <= r3_e0;
            r4_e1 <= r3_e1;
            r4_tv <= r3_tv;
            r4_dir <= r3_dir;
            r4_best <= r3_best;
            r4_tri <= r3_tri;
        end
    end

    // Stages 5 through 7: the four dot products.
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r5_dm[i] <= rti_pkg::fp_mul(r4_e0[i], r4_p[i]);
                r5_um[i] <= rti_pkg::fp_mul(r4_p[i], r4_tv[i]);
                r5_vm[i] <= rti_pkg::fp_mul(r4_dir[i], r4_q[i]);
                r5_tm[i] <= rti_pkg::fp_mul(r4_e1[i], r4_q[i]);
            end
            r5_best <= r4_best;
            r5_tri <= r4_tri;

            r6_d01 <= rti_pkg::fp_add(r5_dm[0], r5_dm[1]);
            r6_u01 <= rti_pkg::fp_add(r5_um[0], r5_um[1]);
            r6_v01 <= rti_pkg::fp_add(r5_vm[0], r5_vm[1]);
            r6_t01 <= rti_pkg::fp_add(r5_tm[0], r5_tm[1]);
            r6_d2 <= r5_dm[2];
            r6_u2 <= r5_um[2];
            r6_v2 <= r5_vm[2];
            r6_t2 <= r5_tm[2];
            r6_best <= r5_best;
            r6_tri <= r5_tri;

            r7_det <= rti_pkg::fp_add(r6_d01, r6_d2);
            r7_u <= rti_pkg::fp_add(r6_u01, r6_u2);
            r7_v <= rti_pkg::fp_add(r6_v01, r6_v2);
            r7_t <= rti_pkg::fp_add(r6_t01, r6_t2);
            r7_best <= r6_best;
            r7_tri <= r6_tri;
        end
    end

    // Determinant tests, and in cull mode the unscaled barycentric tests.
    always_comb begin
        logic        det_ge, det_le;
        logic [31:0] sraw;
        det_ge = rti_pkg::fp_le(i_eps, r7_det);
        det_le = rti_pkg::fp_le(r7_det, i_eps ^ rti_pkg::FP_SIGN);
        sraw = rti_pkg::fp_add(r7_u, r7_v);
        n_side.u = r7_u;
        n_side.v = r7_v;
        n_side.t = r7_t;
        n_side.best = r7_best;
        n_side.tri_id = r7_tri;
        if (i_cull) begin
            n_side.ok_pre = det_ge && rti_pkg::fp_le(sraw, r7_det)
                            && rti_pkg::fp_le(rti_pkg::FP_ZERO, r7_u)
                            && rti_pkg::fp_le(rti_pkg::FP_ZERO, r7_v);
        end else begin
            n_side.ok_pre = det_ge || det_le;
        end
    end

    rti_recip u_recip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r7_vld),
        .i_det   (r7_det),
        .i_side  (n_side),
        .o_valid (rcp_vld),
        .o_inv   (rcp_inv),
        .o_side  (rcp_side)
    );

    // Stage 8: scale by the reciprocal.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r8_u <= rti_pkg::fp_mul(rcp_side.u, rcp_inv);
            r8_v <= rti_pkg::fp_mul(rcp_side.v, rcp_inv);
            r8_t <= rti_pkg::fp_mul(rcp_side.t, rcp_inv);
            r8_best <= rcp_side.best;
            r8_tri <= rcp_side.tri_id;
            r8_ok <= rcp_side.ok_pre;
        end
    end

    // Final barycentric and distance tests.
    always_comb begin
        logic [31:0] ssum;
        logic        bary_ok;
        ssum = rti_pkg::fp_add(r8_u, r8_v);
        bary_ok = i_cull || (rti_pkg::fp_le(ssum, rti_pkg::FP_ONE)
                             && rti_pkg::fp_le(rti_pkg::FP_ZERO, r8_u)
                             && rti_pkg::fp_le(rti_pkg::FP_ZERO, r8_v));
        n_ok = r8_ok && bary_ok && rti_pkg::fp_le(rti_pkg::FP_ZERO, r8_t)
               && rti_pkg::fp_lt(r8_t, r8_best);
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r9_hit <= n_ok;
            r9_t <= n_ok ? r8_t : rti_pkg::FP_ZERO;
            r9_u <= n_ok ? r8_u : rti_pkg::FP_ZERO;
            r9_v <= n_ok ? r8_v : rti_pkg::FP_ZERO;
            r9_tri <= r8_tri;
        end
    end

    assign o_valid = r9_vld;
    assign o_hit = r9_hit;
    assign o_hit_t = r9_t;
    assign o_hit_u = r9_u;
    assign o_hit_v = r9_v;
    assign o_hit_tri_id = r9_tri;

endmodule

// ===== hdl/ray_triangle_intersect.sv =====
// Single-precision ray/triangle intersection engine.
// Input channel (i_valid/o_ready): a load beat (command 0) writes one vertex
// and captures the triangle id; a test beat (command 1) brings one ray and
// its current nearest distance. A load gives no result; every test gives one
// result beat on the output channel (o_valid/i_ready) with the hit flag, t, u,
// v and the stored triangle id. Load all three vertices before the first test.
// Throughput is one beat per cycle while the receiver does not stall. The path
// holds 18 registers, the first loaded at the accepting edge: the capture
// register, six stages of float arithmetic, nine stages of the reciprocal
// divider (seven of them retire four quotient bits each), one scaling stage and
// the output register.
// A load takes effect for the very next test.
// The configuration channel (i_cfg_valid/o_cfg_ready) is always ready and
// writes backface culling (index 0) or the determinant epsilon (index 1);
// write it only while no test is in flight.
// Reset clears the pipeline, the stored triangle id, culling and sets epsilon
// to 1e-5. Vertices are undefined until loaded.
// When the receiver stalls, the whole pipeline holds and o_ready drops; no
// beat is lost or repeated.
module ray_triangle_intersect (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_command,
    input  logic [1:0]  i_vertex_index,
    input  logic [30:0] i_tri_id,
    input  logic [31:0] i_pos_x,
    input  logic [31:0] i_pos_y,
    input  logic [31:0] i_pos_z,
    input  logic [31:0] i_dir_x,
    input  logic [31:0] i_dir_y,
    input  logic [31:0] i_dir_z,
    input  logic [31:0] i_best_t,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_hit,
    output logic [31:0] o_hit_t,
    output logic [31:0] o_hit_u,
    output logic [31:0] o_hit_v,
    output logic [30:0] o_hit_tri_id,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    rti_pkg::t_vec3 r_vtx [0:2];
    logic [30:0]    r_tri;
    logic           r_cull;
    logic [31:0]    r_eps;
    logic           en;
    logic           accept;
    logic           test_go;
    rti_pkg::t_ray  n_ray;

    assign o_ready = en;
    assign o_cfg_ready = 1'b1;
    assign accept = i_valid && en;
    assign test_go = accept && (i_command == rti_pkg::CMD_TEST);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cull <= 1'b0;
            r_eps <= rti_pkg::EPS_DEFAULT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                rti_pkg::CFG_CULL: r_cull <= i_cfg_data[0];
                rti_pkg::CFG_EPS:  r_eps <= i_cfg_data;
                default:           r_eps <= r_eps;
            endcase
        end
    end

    // Triangle id, captured by every load of a valid vertex.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tri <= 31'd0;
        end else if (accept && (i_command == rti_pkg::CMD_LOAD)
                     && (i_vertex_index != 2'd3)) begin
            r_tri <= i_tri_id;
        end
    end

    // Vertex store; a load with vertex index three changes nothing.
    always_ff @(posedge i_clk) begin
        if (accept && (i_command == rti_pkg::CMD_LOAD)) begin
            for (int i = 0; i < 3; i++) begin
                if (i_vertex_index == 2'(i)) begin
                    r_vtx[i] <= {i_pos_z, i_pos_y, i_pos_x};
                end
            end
        end
    end

    // Test beat as it enters the pipeline.
    always_comb begin
        n_ray.org = {i_pos_z, i_pos_y, i_pos_x};
        n_ray.dir = {i_dir_z, i_dir_y, i_dir_x};
        n_ray.v0 = r_vtx[0];
        n_ray.v1 = r_vtx[1];
        n_ray.v2 = r_vtx[2];
        n_ray.best = i_best_t;
        n_ray.tri_id = r_tri;
    end

    rti_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_test       (test_go),
        .i_ray        (n_ray),
        .i_cull       (r_cull),
        .i_eps        (r_eps),
        .o_en         (en),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_hit        (o_hit),
        .o_hit_t      (o_hit_t),
        .o_hit_u      (o_hit_u),
        .o_hit_v      (o_hit_v),
        .o_hit_tri_id (o_hit_tri_id)
    );

endmodule
